// ----- sv/vgd_pkg.sv -----
// vgd_pkg: shared constants for the vertex gather and dedup indexer
// no dependencies
`timescale 1ns / 1ps

package vgd_pkg;
	localparam int ATTR_ENTRIES_DEF   = 1024;
	localparam int UNIQUE_ENTRIES_DEF = 1024;
	localparam int IDX_W    = 10;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 3 * WORD_W;
	localparam int NRM_W    = 3 * WORD_W;
	localparam int TEX_W    = 2 * WORD_W;
	localparam int COL_W    = 4 * WORD_W;
	localparam int VERTEX_W = POS_W + NRM_W + TEX_W + COL_W;

	localparam logic [2:0] OP_LOAD_POS = 3'd0;
	localparam logic [2:0] OP_LOAD_NRM = 3'd1;
	localparam logic [2:0] OP_LOAD_TEX = 3'd2;
	localparam logic [2:0] OP_LOAD_COL = 3'd3;
	localparam logic [2:0] OP_TUPLE    = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [WORD_W-1:0] WHITE_WORD = 32'h3F80_0000;
endpackage

// ----- sv/vgd_in_if.sv -----
// vgd_in_if: input channel, load and tuple items
// depends on nothing
`timescale 1ns / 1ps

interface vgd_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [9:0]  load_slot;
	logic [31:0] word_x;
	logic [31:0] word_y;
	logic [31:0] word_z;
	logic [31:0] word_w;
	logic [9:0]  pos_index;
	logic [9:0]  nrm_index;
	logic [9:0]  tex_index;
	logic [9:0]  col_index;

	modport source (output valid, op, load_slot, word_x, word_y, word_z, word_w,
		pos_index, nrm_index, tex_index, col_index, input ready);
	modport sink (input valid, op, load_slot, word_x, word_y, word_z, word_w,
		pos_index, nrm_index, tex_index, col_index, output ready);
endinterface

// ----- sv/vgd_out_if.sv -----
// vgd_out_if: result channel, one item per tuple
// depends on nothing
`timescale 1ns / 1ps

interface vgd_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] vertex_index;
	logic       is_new;
	logic [9:0] src_pos_index;
	logic [9:0] src_nrm_index;
	logic [9:0] src_tex_index;
	logic [9:0] src_col_index;
	logic [1:0] status;

	modport source (output valid, vertex_index, is_new, src_pos_index, src_nrm_index,
		src_tex_index, src_col_index, status, input ready);
	modport sink (input valid, vertex_index, is_new, src_pos_index, src_nrm_index,
		src_tex_index, src_col_index, status, output ready);
endinterface

// ----- sv/vgd_ram.sv -----
// vgd_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module vgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/vertex_gather_dedup_indexer_top.sv -----
// channel  | dir | carries
// in_ch    | in  | load items (op 0..3) and tuple items (op 4)
// out_ch   | out | one result per tuple
// cfg      | in  | color_enabled write (cfg_we, cfg_wdata)
//
// a load is written while idle; a tuple is resolved by the
// linear scan of the unique table through its single read port and one 384-bit compare
// in_ch.ready is high only while the sequencer is idle
// a finished result waits in the output register; the next item is taken meanwhile
// reset clears the fill counts, the unique count, color_enabled and the output valid flag; ram contents are not cleared
// depends on vgd_pkg, vgd_in_if, vgd_out_if, vgd_ram
`timescale 1ns / 1ps

module vertex_gather_dedup_indexer_top
	import vgd_pkg::*;
#(
	parameter int ATTR_ENTRIES   = ATTR_ENTRIES_DEF,
	parameter int UNIQUE_ENTRIES = UNIQUE_ENTRIES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	vgd_in_if.sink    in_ch,
	vgd_out_if.source out_ch,
	input  logic  cfg_we,
	input  logic  cfg_wdata
);
	localparam int AAW = (ATTR_ENTRIES > 1) ? $clog2(ATTR_ENTRIES) : 1;
	localparam int ACW = $clog2(ATTR_ENTRIES + 1);
	localparam int UAW = (UNIQUE_ENTRIES > 1) ? $clog2(UNIQUE_ENTRIES) : 1;
	localparam int UCW = $clog2(UNIQUE_ENTRIES + 1);

	typedef enum logic [2:0] {S_IDLE, S_GATHER, S_SEARCH, S_FINISH} state_t;

	state_t state_q;
	logic color_en_q;
	logic [ACW-1:0] cnt_pos_q, cnt_nrm_q, cnt_tex_q, cnt_col_q;
	logic [UCW-1:0] ucount_q, issue_q;
	logic cmp_vld_s1;
	logic [UAW-1:0] cmp_idx_s1;
	logic [VERTEX_W-1:0] vertex_q;
	logic [IDX_W-1:0] pi_q, ni_q, ti_q, ci_q;
	logic [IDX_W-1:0] res_idx_q;
	logic res_new_q;
	logic [1:0] res_status_q;

	logic out_valid_q;
	logic [IDX_W-1:0] o_vidx_q, o_pi_q, o_ni_q, o_ti_q, o_ci_q;
	logic o_new_q;
	logic [1:0] o_status_q;

	logic acc, load_ok, range_bad;
	logic [POS_W-1:0] pos_rd;
	logic [NRM_W-1:0] nrm_rd;
	logic [TEX_W-1:0] tex_rd;
	logic [COL_W-1:0] col_rd;
	logic [VERTEX_W-1:0] uniq_rd;
	logic issue_more, hit, app_we;

	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign load_ok = (32'(in_ch.load_slot) < ATTR_ENTRIES);

	assign range_bad = (32'(in_ch.pos_index) >= 32'(cnt_pos_q))
		|| (32'(in_ch.nrm_index) >= 32'(cnt_nrm_q))
		|| (32'(in_ch.tex_index) >= 32'(cnt_tex_q))
		|| (color_en_q && (32'(in_ch.col_index) >= 32'(cnt_col_q)));

	assign issue_more = (issue_q < ucount_q);
	assign hit = cmp_vld_s1 && (uniq_rd == vertex_q);
	assign app_we = (state_q == S_SEARCH) && !hit && !issue_more && !cmp_vld_s1
		&& (32'(ucount_q) < UNIQUE_ENTRIES);

	vgd_ram #(.WIDTH(POS_W), .DEPTH(ATTR_ENTRIES)) u_pos (
		.clk(clk), .we(acc && load_ok && in_ch.op == OP_LOAD_POS),
		.waddr(AAW'(in_ch.load_slot)), .wdata({in_ch.word_x, in_ch.word_y, in_ch.word_z}),
		.raddr(AAW'(in_ch.pos_index)), .rdata(pos_rd));
	vgd_ram #(.WIDTH(NRM_W), .DEPTH(ATTR_ENTRIES)) u_nrm (
		.clk(clk), .we(acc && load_ok && in_ch.op == OP_LOAD_NRM),
		.waddr(AAW'(in_ch.load_slot)), .wdata({in_ch.word_x, in_ch.word_y, in_ch.word_z}),
		.raddr(AAW'(in_ch.nrm_index)), .rdata(nrm_rd));
	vgd_ram #(.WIDTH(TEX_W), .DEPTH(ATTR_ENTRIES)) u_tex (
		.clk(clk), .we(acc && load_ok && in_ch.op == OP_LOAD_TEX),
		.waddr(AAW'(in_ch.load_slot)), .wdata({in_ch.word_x, in_ch.word_y}),
		.raddr(AAW'(in_ch.tex_index)), .rdata(tex_rd));
	vgd_ram #(.WIDTH(COL_W), .DEPTH(ATTR_ENTRIES)) u_col (
		.clk(clk), .we(acc && load_ok && in_ch.op == OP_LOAD_COL),
		.waddr(AAW'(in_ch.load_slot)),
		.wdata({in_ch.word_x, in_ch.word_y, in_ch.word_z, in_ch.word_w}),
		.raddr(AAW'(in_ch.col_index)), .rdata(col_rd));
	vgd_ram #(.WIDTH(VERTEX_W), .DEPTH(UNIQUE_ENTRIES)) u_uniq (
		.clk(clk), .we(app_we), .waddr(UAW'(ucount_q)), .wdata(vertex_q),
		.raddr(UAW'(issue_q)), .rdata(uniq_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			color_en_q  <= 1'b0;
			cnt_pos_q   <= '0;
			cnt_nrm_q   <= '0;
			cnt_tex_q   <= '0;
			cnt_col_q   <= '0;
			ucount_q    <= '0;
			issue_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_en_q <= cfg_wdata;
			end
			// in finish the output register is reloaded below
			if (out_ch.valid && out_ch.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						// fill marks: one past the highest slot loaded
						if (load_ok) begin
							case (in_ch.op)
								OP_LOAD_POS: if (32'(in_ch.load_slot) >= 32'(cnt_pos_q))
									cnt_pos_q <= ACW'(32'(in_ch.load_slot) + 1);
								OP_LOAD_NRM: if (32'(in_ch.load_slot) >= 32'(cnt_nrm_q))
									cnt_nrm_q <= ACW'(32'(in_ch.load_slot) + 1);
								OP_LOAD_TEX: if (32'(in_ch.load_slot) >= 32'(cnt_tex_q))
									cnt_tex_q <= ACW'(32'(in_ch.load_slot) + 1);
								OP_LOAD_COL: if (32'(in_ch.load_slot) >= 32'(cnt_col_q))
									cnt_col_q <= ACW'(32'(in_ch.load_slot) + 1);
								default: ;
							endcase
						end
						if (in_ch.op == OP_TUPLE) begin
							pi_q <= in_ch.pos_index;
							ni_q <= in_ch.nrm_index;
							ti_q <= in_ch.tex_index;
							ci_q <= color_en_q ? in_ch.col_index : '0;
							res_idx_q <= '0;
							res_new_q <= 1'b0;
							if (range_bad) begin
								res_status_q <= STATUS_RANGE;
								state_q <= S_FINISH;
							end else begin
								res_status_q <= STATUS_OK;
								state_q <= S_GATHER;
							end
						end
					end
				end
				S_GATHER: begin
					vertex_q <= {pos_rd, nrm_rd, tex_rd,
						color_en_q ? col_rd : {4{WHITE_WORD}}};
					issue_q <= '0;
					cmp_vld_s1 <= 1'b0;
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					cmp_vld_s1 <= issue_more && !hit;
					cmp_idx_s1 <= UAW'(issue_q);
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end
					if (hit) begin
						res_idx_q <= IDX_W'(cmp_idx_s1);
						state_q <= S_FINISH;
					end else if (!issue_more && !cmp_vld_s1) begin
						if (app_we) begin
							res_idx_q <= IDX_W'(ucount_q);
							res_new_q <= 1'b1;
							ucount_q <= ucount_q + 1'b1;
						end else begin
							res_status_q <= STATUS_FULL;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						o_vidx_q    <= res_idx_q;
						o_new_q     <= res_new_q;
						o_pi_q      <= pi_q;
						o_ni_q      <= ni_q;
						o_ti_q      <= ti_q;
						o_ci_q      <= ci_q;
						o_status_q  <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.vertex_index     = o_vidx_q;
	assign out_ch.is_new           = o_new_q;
	assign out_ch.src_pos_index    = o_pi_q;
	assign out_ch.src_nrm_index    = o_ni_q;
	assign out_ch.src_tex_index    = o_ti_q;
	assign out_ch.src_col_index    = o_ci_q;
	assign out_ch.status           = o_status_q;

`ifndef ASSERT_OFF
	a_ucount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ucount_q) <= UNIQUE_ENTRIES) else $error("unique count beyond table");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != STATUS_OK |-> !out_ch.is_new
		&& out_ch.vertex_index == '0) else $error("error result carries an index");
	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		app_we |=> ucount_q == $past(ucount_q) + 1'b1) else $error("append lost");
	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH) else $error("stray result");
`endif
endmodule
